/* rtl/fbde_pkg.sv */
// shared constants, codes and types of the page framebuffer draw engine
package fbde_pkg;

  // screen and store geometry
  localparam int SCREEN_WIDTH  = 128;
  localparam int SCREEN_HEIGHT = 64;
  localparam int STORE_BYTES   = 1024;

  // page layout: eight rows per byte
  localparam int PAGE_ROWS  = 8;
  localparam int PAGE_SHIFT = 3;
  localparam int PAGES      = (SCREEN_HEIGHT + PAGE_ROWS - 1) / PAGE_ROWS;

  // port widths fixed by the command format
  localparam int KIND_W     = 3;
  localparam int COORD_IN_W = 16;
  localparam int READ_IDX_W = 10;
  localparam int DATA_W     = 8;

  // internal widths
  localparam int MAX_DIM = (SCREEN_WIDTH > SCREEN_HEIGHT) ? SCREEN_WIDTH : SCREEN_HEIGHT;
  localparam int COORD_W = $clog2(MAX_DIM + 1);
  localparam int ADDR_W  = $clog2(STORE_BYTES);
  localparam int PLOT_W  = $clog2(PAGES * SCREEN_WIDTH + 1);
  localparam int STORE_W = $clog2(STORE_BYTES + 1);
  localparam int IDX_A   = (PLOT_W > STORE_W) ? PLOT_W : STORE_W;
  localparam int IDX_W   = ((IDX_A > READ_IDX_W) ? IDX_A : READ_IDX_W) + 1;

  // command kinds
  localparam logic [KIND_W-1:0] KIND_PIXEL = 3'd0;
  localparam logic [KIND_W-1:0] KIND_HRUN  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_VRUN  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_CLEAR = 3'd3;
  localparam logic [KIND_W-1:0] KIND_READ  = 3'd4;

  // memory operation codes from the sequencer
  localparam logic [1:0] OP_NONE  = 2'd0;
  localparam logic [1:0] OP_PLOT  = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;
  localparam logic [1:0] OP_READ  = 2'd3;

  // one memory operation per cycle from the sequencer to the datapath
  typedef struct packed {
    logic [1:0]         code;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic               on;
    logic [ADDR_W-1:0]  addr;
    logic               beyond;
  } mem_op_t;

endpackage

/* rtl/fbde_ram.sv */
// generic single-clock ram, one write port and one registered read port
module fbde_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

/* rtl/fbde_seq.sv */
// command sequencer: clips runs, walks pixels, sweeps clears, issues reads
module fbde_seq (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic [fbde_pkg::KIND_W-1:0]         kind,
  input  logic signed [fbde_pkg::COORD_IN_W-1:0] x,
  input  logic signed [fbde_pkg::COORD_IN_W-1:0] y,
  input  logic signed [fbde_pkg::COORD_IN_W-1:0] length,
  input  logic                                pixel_on,
  input  logic [fbde_pkg::READ_IDX_W-1:0]     read_index,
  output fbde_pkg::mem_op_t                   op
);
  import fbde_pkg::*;

  localparam int SW = COORD_IN_W + 1;
  localparam logic signed [SW-1:0] WIDTH_S  = SW'(SCREEN_WIDTH);
  localparam logic signed [SW-1:0] HEIGHT_S = SW'(SCREEN_HEIGHT);
  localparam logic [ADDR_W-1:0]    LAST_ADDR = ADDR_W'(STORE_BYTES - 1);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_CLEAR = 2'd1;
  localparam logic [1:0] S_RUN   = 2'd2;
  localparam logic [1:0] S_READ  = 2'd3;

  logic [1:0]               state;
  logic [ADDR_W-1:0]        cnt;
  logic                     phase;
  logic [COORD_W-1:0]       cur;
  logic [COORD_W-1:0]       hi;
  logic [COORD_W-1:0]       fixed;
  logic                     horiz;
  logic                     on;
  logic [READ_IDX_W-1:0]    rd_idx;

  logic                     horiz_cmd;
  logic signed [SW-1:0]     run_start;
  logic signed [SW-1:0]     run_fix;
  logic signed [SW-1:0]     run_len;
  logic signed [SW-1:0]     run_end;
  logic signed [SW-1:0]     run_lim;
  logic signed [SW-1:0]     fix_lim;
  logic signed [SW-1:0]     lo_s;
  logic signed [SW-1:0]     hi_s;
  logic                     run_ok;
  logic [COORD_W-1:0]       cur_inc;

  assign busy    = (state != S_IDLE);
  assign cur_inc = cur + COORD_W'(1);

  // clip a run to the screen; a single pixel is a horizontal run of one
  always_comb begin
    horiz_cmd = (kind != KIND_VRUN);
    run_start = horiz_cmd ? SW'(x) : SW'(y);
    run_fix   = horiz_cmd ? SW'(y) : SW'(x);
    run_lim   = horiz_cmd ? WIDTH_S : HEIGHT_S;
    fix_lim   = horiz_cmd ? HEIGHT_S : WIDTH_S;
    run_len   = (kind == KIND_PIXEL) ? SW'(1) : SW'(length);
    run_end   = run_start + run_len;
    lo_s      = (run_start < 0) ? '0 : run_start;
    hi_s      = (run_end > run_lim) ? run_lim : run_end;
    run_ok    = (run_fix >= 0) && (run_fix < fix_lim) && (run_len > 0) && (lo_s < hi_s);
  end

  // sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      cnt   <= '0;
      phase <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (start) begin
            priority case (kind)
              KIND_PIXEL, KIND_HRUN, KIND_VRUN: begin
                if (run_ok) begin
                  state <= S_RUN;
                  phase <= 1'b0;
                  cur   <= COORD_W'(lo_s);
                  hi    <= COORD_W'(hi_s);
                  fixed <= COORD_W'(run_fix);
                  horiz <= horiz_cmd;
                  on    <= pixel_on;
                end
              end
              KIND_CLEAR: begin
                state <= S_CLEAR;
                cnt   <= '0;
              end
              KIND_READ: begin
                state  <= S_READ;
                rd_idx <= read_index;
              end
              default: begin
              end
            endcase
          end
        end
        S_CLEAR: begin
          cnt <= cnt + ADDR_W'(1);
          if (cnt == LAST_ADDR) begin
            state <= S_IDLE;
          end
        end
        S_RUN: begin
          phase <= ~phase;
          if (!phase) begin
            cur <= cur_inc;
            if (cur_inc == hi) begin
              state <= S_IDLE;
            end
          end
        end
        S_READ: begin
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // memory operation for this cycle; during a run, plots alternate with empty operations
  always_comb begin
    op = '0;
    unique case (state)
      S_CLEAR: begin
        op.code = OP_CLEAR;
        op.addr = cnt;
      end
      S_RUN: begin
        if (!phase) begin
          op.code = OP_PLOT;
          op.x    = horiz ? cur : fixed;
          op.y    = horiz ? fixed : cur;
          op.on   = on;
        end
      end
      S_READ: begin
        op.code   = OP_READ;
        op.addr   = ADDR_W'(rd_idx);
        op.beyond = (IDX_W'(rd_idx) >= IDX_W'(STORE_BYTES));
      end
      default: begin
      end
    endcase
  end

endmodule

/* rtl/fbde_rmw.sv */
// read-modify-write datapath around the frame store
module fbde_rmw (
  input  logic                            clk,
  input  logic                            rst,
  input  fbde_pkg::mem_op_t               op,
  output logic                            read_valid,
  output logic [fbde_pkg::DATA_W-1:0]     read_data
);
  import fbde_pkg::*;

  logic [IDX_W-1:0]  plot_idx;
  logic              plot_ok;
  logic [ADDR_W-1:0] raddr;
  logic [DATA_W-1:0] mask;
  logic [DATA_W-1:0] rdata;

  logic [1:0]        s1_code;
  logic [ADDR_W-1:0] s1_addr;
  logic [DATA_W-1:0] s1_mask;
  logic              s1_on;
  logic              s1_beyond;

  logic              we;
  logic [DATA_W-1:0] wdata;

  // page address and row mask of a pixel
  always_comb begin
    plot_idx = (IDX_W'(op.y >> PAGE_SHIFT) * IDX_W'(SCREEN_WIDTH)) + IDX_W'(op.x);
    plot_ok  = (plot_idx < IDX_W'(STORE_BYTES));
    mask     = DATA_W'(1) << op.y[PAGE_SHIFT-1:0];
    raddr    = (op.code == OP_PLOT) ? ADDR_W'(plot_idx) : op.addr;
  end

  // stage one: operation waits for the read data
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_code <= OP_NONE;
    end else if (op.code == OP_PLOT && !plot_ok) begin
      s1_code <= OP_NONE;
    end else begin
      s1_code <= op.code;
    end
    s1_addr   <= raddr;
    s1_mask   <= mask;
    s1_on     <= op.on;
    s1_beyond <= op.beyond;
  end

  // write back: modified byte for a plot, zero for a clear
  always_comb begin
    we    = (s1_code == OP_PLOT) || (s1_code == OP_CLEAR);
    wdata = (s1_code == OP_CLEAR) ? '0 :
            ((rdata & ~s1_mask) | (s1_on ? s1_mask : '0));
  end

  fbde_ram #(
    .WIDTH (DATA_W),
    .DEPTH (STORE_BYTES)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (s1_addr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  // registered read result
  always_ff @(posedge clk) begin
    if (rst) begin
      read_valid <= 1'b0;
    end else begin
      read_valid <= (s1_code == OP_READ);
    end
    read_data <= s1_beyond ? '0 : rdata;
  end

endmodule

/* rtl/page_framebuffer_draw_engine.sv */
// top level of the page framebuffer draw engine
// a read passes the sequencer read state, the stage-one register and the
//   result register before read_valid; a new command is taken only while
//   busy is low; one store port pair paced by the rmw loop
// reset: rst clears control, then a clearing pass over all STORE_BYTES bytes
//   zeroes the store with busy high; the receiver cannot stall results
module page_framebuffer_draw_engine (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   start,
  output logic                                   busy,
  input  logic [fbde_pkg::KIND_W-1:0]            kind,
  input  logic signed [fbde_pkg::COORD_IN_W-1:0] x,
  input  logic signed [fbde_pkg::COORD_IN_W-1:0] y,
  input  logic signed [fbde_pkg::COORD_IN_W-1:0] length,
  input  logic                                   pixel_on,
  input  logic [fbde_pkg::READ_IDX_W-1:0]        read_index,
  output logic                                   read_valid,
  output logic [fbde_pkg::DATA_W-1:0]            read_data
);
  import fbde_pkg::*;

  mem_op_t op;

  // command sequencing
  fbde_seq u_seq (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .kind       (kind),
    .x          (x),
    .y          (y),
    .length     (length),
    .pixel_on   (pixel_on),
    .read_index (read_index),
    .op         (op)
  );

  // store access
  fbde_rmw u_rmw (
    .clk        (clk),
    .rst        (rst),
    .op         (op),
    .read_valid (read_valid),
    .read_data  (read_data)
  );

endmodule

/* rtl/fbde_checker.sv */
// port-level checker for the draw engine, bound to the top level
module fbde_checker (
  input logic                                   clk,
  input logic                                   rst,
  input logic                                   start,
  input logic                                   busy,
  input logic [fbde_pkg::KIND_W-1:0]            kind,
  input logic                                   read_valid
);
  import fbde_pkg::*;

  logic read_req;
  assign read_req = start && !busy && (kind == KIND_READ);

  // clearing pass follows reset
  a_reset_clear: assert property (@(posedge clk) rst |=> busy)
    else $error("busy low right after reset");

  // every read request is followed by a result
  a_read_result: assert property (@(posedge clk) disable iff (rst)
    read_req |-> ##3 read_valid)
    else $error("read result missing");

  // no result without a read request
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    read_valid |-> $past(read_req, 3))
    else $error("result without read request");

  // results never arrive back to back
  a_spaced: assert property (@(posedge clk) disable iff (rst)
    read_valid |=> !read_valid)
    else $error("results back to back");

  // clear request makes the engine busy
  a_clear_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (kind == KIND_CLEAR)) |=> busy)
    else $error("clear request not taken");

endmodule

bind page_framebuffer_draw_engine fbde_checker u_checker (.*);
